// ===== design/prc_pkg.sv =====
package prc_pkg;

  // Milliseconds per second and the reciprocal used to turn elapsed
  // milliseconds into whole seconds. The elapsed time is first shifted down
  // by three (a divide by eight), then multiplied by ceil(2^36 / 125).
  // The result is exact for every 29-bit quotient input.
  localparam int unsigned MsPerSec   = 1000;
  localparam int unsigned MsLimW     = 26;
  localparam int unsigned SecRecipW  = 30;
  localparam logic [SecRecipW-1:0] SecRecip = 30'd549755814;
  localparam int unsigned SecShift   = 36;
  localparam int unsigned SecProdW   = 59;

  localparam int unsigned InTdataW   = 56;
  localparam int unsigned OutTdataW  = 32;
  localparam int unsigned RunSecW    = 23;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_RUN    = 2'd0,
    CFG_START_DLY  = 2'd1,
    CFG_TANK_EMPTY = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] max_run_s;
    logic [15:0] start_dly_s;
    logic [14:0] tank_empty_mm;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               water_present;
    logic               service_mode;
    logic               water_alarm;
    logic signed [15:0] distance_mm;
    logic               clear_lock;
  } in_item_t;

  // Outcome of one evaluation. The elapsed field is already zero unless the
  // pump stopped in this evaluation.
  typedef struct packed {
    logic        pump_on;
    logic        alarm_raise;
    logic        run_time_valid;
    logic        lock_active;
    logic        delay_running;
    logic [31:0] elapsed_ms;
  } eval_t;

endpackage

// ===== design/prc_cfg_regs.sv =====
module prc_cfg_regs
  import prc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_RUN:    cfg_d.max_run_s     = cfg_wdata_i;
        CFG_START_DLY:  cfg_d.start_dly_s   = cfg_wdata_i;
        CFG_TANK_EMPTY: cfg_d.tank_empty_mm = cfg_wdata_i[14:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_run_s     <= 16'd60;
      cfg_q.start_dly_s   <= 16'd5;
      cfg_q.tank_empty_mm <= 15'd500;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/prc_core.sv =====
module prc_core
  import prc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output eval_t    eval_o
);

  logic        pump_q, pump_d;
  logic        dly_q, dly_d;
  logic        lock_q, lock_d;
  logic [31:0] run_start_q, run_start_d;
  logic [31:0] dly_start_q, dly_start_d;

  logic        lock_clr;
  logic [31:0] run_eff, dly_eff, run_el, dly_el;
  logic [MsLimW-1:0] run_lim, dly_lim;
  logic        over_run, supply_dry, dly_done;
  logic        stop, alarm;

  always_comb begin
    lock_clr = item_i.clear_lock ? 1'b0 : lock_q;
    // A start time later than now means the millisecond counter wrapped.
    run_eff  = (item_i.now_ms < run_start_q) ? item_i.now_ms : run_start_q;
    dly_eff  = (item_i.now_ms < dly_start_q) ? item_i.now_ms : dly_start_q;
    run_el   = item_i.now_ms - run_eff;
    dly_el   = item_i.now_ms - dly_eff;
    run_lim  = MsLimW'(cfg_i.max_run_s) * MsLimW'(MsPerSec);
    dly_lim  = MsLimW'(cfg_i.start_dly_s) * MsLimW'(MsPerSec);
    over_run = pump_q && (run_el > {6'b0, run_lim});
    dly_done = dly_el >= {6'b0, dly_lim};
    supply_dry = !item_i.distance_mm[15] &&
                 (item_i.distance_mm[14:0] >= cfg_i.tank_empty_mm);

    pump_d      = pump_q;
    dly_d       = dly_q;
    lock_d      = lock_clr;
    run_start_d = run_eff;
    dly_start_d = dly_eff;
    stop        = 1'b0;
    alarm       = 1'b0;

    if (item_i.service_mode) begin
      stop = pump_q;
    end else if (over_run) begin
      stop   = 1'b1;
      lock_d = 1'b1;
      alarm  = 1'b1;
    end else if (lock_clr || item_i.water_alarm) begin
      stop = pump_q;
    end else if (pump_q && supply_dry) begin
      stop  = 1'b1;
      dly_d = 1'b0;
      alarm = 1'b1;
    end else if (!item_i.water_present && pump_q) begin
      stop  = 1'b1;
      dly_d = 1'b0;
    end else if (item_i.water_present && !pump_q && !dly_q) begin
      dly_d       = 1'b1;
      dly_start_d = item_i.now_ms;
    end else if (dly_q && !pump_q && dly_done) begin
      pump_d      = 1'b1;
      run_start_d = item_i.now_ms;
      dly_d       = 1'b0;
    end

    if (stop) begin
      pump_d      = 1'b0;
      run_start_d = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pump_q      <= 1'b0;
      dly_q       <= 1'b0;
      lock_q      <= 1'b0;
      run_start_q <= 32'd0;
      dly_start_q <= 32'd0;
    end else if (adv_i) begin
      pump_q      <= pump_d;
      dly_q       <= dly_d;
      lock_q      <= lock_d;
      run_start_q <= run_start_d;
      dly_start_q <= dly_start_d;
    end
  end

  assign eval_o.pump_on        = pump_d;
  assign eval_o.alarm_raise    = alarm;
  assign eval_o.run_time_valid = stop;
  assign eval_o.lock_active    = lock_d;
  assign eval_o.delay_running  = dly_d;
  assign eval_o.elapsed_ms     = stop ? run_el : 32'd0;

endmodule

// ===== design/pump_refill_controller.sv =====
// Channel     | Dir | Beat contents
// s_axis      | in  | one evaluation request (now, sensors, distance, lock clear)
// m_axis      | out | one evaluation result (pump, alarm, stop report, flags)
// cfg         | in  | register write: index and 16-bit data, no handshake
//
// A beat passes three registers: the input register, loaded at the accepting edge, the
// evaluation register, and the output register after the millisecond-to-second multiply.
// One beat is accepted per cycle unless a stall on m_axis has filled the pipeline.
// Reset clears the pump, delay and lock flags, both start times and the stage valid bits,
// and returns the registers to 60 s, 5 s and 500 mm.
// A stall on m_axis holds each full stage and backs up through the pipeline to s_axis_tready.
module pump_refill_controller
  import prc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // now_ms[31:0], water_present[32], service_mode[33], water_alarm[34],
  // distance_mm[50:35], clear_lock[51], zero fill [55:52]
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // pump_on[0], alarm_raise[1], run_time_valid[2], run_seconds[25:3],
  // lock_active[26], delay_running[27], zero fill [31:28]
  output logic [OutTdataW-1:0] m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i
);

  cfg_t     cfg;
  in_item_t in_q;
  eval_t    eval_d, ev_q;
  logic     in_v_q, ev_v_q, out_v_q;
  logic     in_rdy, ev_rdy, out_rdy;
  logic     in_adv, ev_adv;
  logic [SecProdW-1:0] sec_prod;

  typedef struct packed {
    logic               pump_on;
    logic               alarm_raise;
    logic               run_time_valid;
    logic [RunSecW-1:0] run_seconds;
    logic               lock_active;
    logic               delay_running;
  } out_beat_t;

  out_beat_t out_q;

  // Register writes must arrive only while the pipeline is empty; the block does not enforce it.
  prc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // A stage may load when it is empty or when its content moves on.
  assign out_rdy = !out_v_q || m_axis_tready;
  assign ev_rdy  = !ev_v_q || out_rdy;
  assign in_rdy  = !in_v_q || ev_rdy;
  assign ev_adv  = ev_v_q && out_rdy;
  assign in_adv  = in_v_q && ev_rdy;
  assign s_axis_tready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      ev_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_rdy)  in_v_q  <= s_axis_tvalid;
      if (ev_rdy)  ev_v_q  <= in_v_q;
      if (out_rdy) out_v_q <= ev_v_q;
    end
  end

  // Input register: unpack the beat into its fields.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && in_rdy) begin
      in_q.now_ms        <= s_axis_tdata[31:0];
      in_q.water_present <= s_axis_tdata[32];
      in_q.service_mode  <= s_axis_tdata[33];
      in_q.water_alarm   <= s_axis_tdata[34];
      in_q.distance_mm   <= s_axis_tdata[50:35];
      in_q.clear_lock    <= s_axis_tdata[51];
    end
  end

  // The controller state advances exactly when the evaluated beat moves into
  // the evaluation register.
  prc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (in_adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .eval_o (eval_d)
  );

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      ev_q <= eval_d;
    end
  end

  // Whole seconds: floor(ms / 1000) = floor((ms >> 3) * SecRecip >> 36).
  assign sec_prod = SecProdW'(ev_q.elapsed_ms[31:3]) * SecProdW'(SecRecip);

  always_ff @(posedge clk_i) begin
    if (ev_adv) begin
      out_q.pump_on        <= ev_q.pump_on;
      out_q.alarm_raise    <= ev_q.alarm_raise;
      out_q.run_time_valid <= ev_q.run_time_valid;
      out_q.run_seconds    <= sec_prod[SecShift +: RunSecW];
      out_q.lock_active    <= ev_q.lock_active;
      out_q.delay_running  <= ev_q.delay_running;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'b0, out_q.delay_running, out_q.lock_active, out_q.run_seconds,
                          out_q.run_time_valid, out_q.alarm_raise, out_q.pump_on};

  // A stop always leaves the pump off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[2] && m_axis_tdata[0]))
    else $error("stop reported with pump still on");

  // Every alarm comes from a stop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[2])
    else $error("alarm raised without a pump stop");

  // A nonzero run time is only reported with a stop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[25:3] == '0)
    else $error("run seconds reported without a stop");

  // The pump and the start delay never run at the same time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[27]))
    else $error("pump on while start delay is counting");

endmodule
